### src/window_min_color_distance_assert.svh
`ifndef WINDOW_MIN_COLOR_DISTANCE_ASSERT_SVH
`define WINDOW_MIN_COLOR_DISTANCE_ASSERT_SVH

// The condition must never be true at a clock edge outside reset.
`define WMCD_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define WMCD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define WMCD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wmcd_pkg.sv
`timescale 1ns / 1ps

package wmcd_pkg;

   localparam int MAX_ROWS   = 512;
   localparam int MAX_COLS   = 1024;
   localparam int ROW_W      = 9;
   localparam int COL_W      = 10;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int PIXEL_W    = 24;
   localparam int D2_W       = 18;
   localparam int DIST_W     = 17;
   localparam int ROOT_STEPS = DIST_W;
   localparam int RAD_W      = 2 * ROOT_STEPS;
   localparam int REM_W      = DIST_W + 2;
   localparam int STEP_W     = 5;

   localparam logic [9:0]  ROWS_RESET = 10'd480;
   localparam logic [10:0] COLS_RESET = 11'd640;
   localparam logic [3:0]  KERN_RESET = 4'd5;
   localparam logic [9:0]  ROWS_LIMIT = 10'd512;
   localparam logic [10:0] COLS_LIMIT = 11'd1024;

   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_KERN = 2'd2;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
   } req_word_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              found;
   } rsp_word_type;

endpackage

### src/window_min_color_distance.sv
`timescale 1ns / 1ps

// A store word writes one pixel of the reference frame. A query word scans the
// square search window through the single read port of the frame memory, one pixel
// per cycle. A query then drains the read pipeline, runs the bit-serial square root
// when a non-black pixel is found, and loads the result. A query that is black,
// whose window side is zero, or whose window reaches row or column zero or runs past
// the frame edge skips the scan and goes straight to the result. A stalled result
// holds the block in its done state until the result register frees. New words are
// held off while a query is in progress; the frame memory is undefined until written.

`include "window_min_color_distance_assert.svh"

module window_min_color_distance import wmcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [10:0]  csr_wdata
);

   logic [PIXEL_W-1:0] frame_mem [0:MEM_DEPTH-1];

   state_type state_ff, state_in;

   logic [9:0]  rows_ff;
   logic [10:0] cols_ff;
   logic [3:0]  kern_ff;

   logic [ROW_W-1:0] row0_ff;
   logic [COL_W-1:0] col0_ff;
   logic [7:0]       qb_ff, qg_ff, qr_ff;
   logic [3:0]       i_ff, j_ff;

   logic               rd_vld_ff;
   logic [PIXEL_W-1:0] rd_data_ff;
   logic               sq_vld_ff, sq_nz_ff;
   logic [15:0]        sqb_ff, sqg_ff, sqr_ff;

   logic [D2_W-1:0] best_ff;
   logic            found_ff;

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [DIST_W-1:0] root_ff;
   logic [STEP_W-1:0] step_ff;

   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   logic               req_take, wr_en, issue, issue_last, rsp_load, skip;
   logic               root_start;
   logic [ADDR_W-1:0]  rd_addr;
   logic [9:0]         rows_eff;
   logic [10:0]        cols_eff;
   logic [2:0]         half;
   logic [7:0]         db, dg, dr;
   logic [D2_W-1:0]    d2;
   logic [REM_W+1:0]   rem_t, trial;

   assign req_take   = req_valid && !req_stall;
   assign wr_en      = req_take && req_data.kind == KIND_STORE;
   assign rows_eff   = (rows_ff < ROWS_LIMIT) ? rows_ff : ROWS_LIMIT;
   assign cols_eff   = (cols_ff < COLS_LIMIT) ? cols_ff : COLS_LIMIT;
   assign half       = kern_ff[3:1];
   assign skip       = ({req_data.blue, req_data.green, req_data.red} == '0)
                    || kern_ff == '0
                    || !(req_data.col > {7'd0, half})
                    || !(req_data.row > {6'd0, half})
                    || !({1'b0, req_data.col} + {8'd0, half} < cols_eff)
                    || !({1'b0, req_data.row} + {7'd0, half} < rows_eff);
   assign issue_last = (i_ff == kern_ff - 4'd1) && (j_ff == kern_ff - 4'd1);
   assign rd_addr    = {row0_ff + {5'd0, i_ff}, col0_ff + {6'd0, j_ff}};

   always_comb begin
      state_in   = state_ff;
      req_stall  = state_ff != ST_IDLE;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      root_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_data.kind == KIND_QUERY) begin
               state_in = skip ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue = 1'b1;
            if (issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !sq_vld_ff) begin
               root_start = found_ff;
               state_in   = found_ff ? ST_ROOT : ST_DONE;
            end
         end
         ST_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
         kern_ff <= KERN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata[9:0];
            CSR_COLS: cols_ff <= csr_wdata;
            CSR_KERN: kern_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[{req_data.row, req_data.col}] <= {req_data.blue, req_data.green, req_data.red};
      end
      if (issue) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         row0_ff <= req_data.row - {6'd0, half};
         col0_ff <= req_data.col - {7'd0, half};
         qb_ff   <= req_data.blue;
         qg_ff   <= req_data.green;
         qr_ff   <= req_data.red;
         i_ff    <= '0;
         j_ff    <= '0;
      end else if (issue) begin
         if (j_ff == kern_ff - 4'd1) begin
            j_ff <= '0;
            i_ff <= i_ff + 4'd1;
         end else begin
            j_ff <= j_ff + 4'd1;
         end
      end
   end

   always_comb begin
      db = (qb_ff > rd_data_ff[23:16]) ? qb_ff - rd_data_ff[23:16] : rd_data_ff[23:16] - qb_ff;
      dg = (qg_ff > rd_data_ff[15:8])  ? qg_ff - rd_data_ff[15:8]  : rd_data_ff[15:8] - qg_ff;
      dr = (qr_ff > rd_data_ff[7:0])   ? qr_ff - rd_data_ff[7:0]   : rd_data_ff[7:0] - qr_ff;
      d2 = {2'd0, sqb_ff} + {2'd0, sqg_ff} + {2'd0, sqr_ff};
   end

   always_ff @(posedge clock) begin
      sqb_ff   <= {8'd0, db} * {8'd0, db};
      sqg_ff   <= {8'd0, dg} * {8'd0, dg};
      sqr_ff   <= {8'd0, dr} * {8'd0, dr};
      sq_nz_ff <= rd_data_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
         sq_vld_ff <= rd_vld_ff;
         if (req_take) begin
            found_ff <= 1'b0;
         end else if (sq_vld_ff && sq_nz_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_vld_ff && sq_nz_ff && (!found_ff || d2 < best_ff)) begin
         best_ff <= d2;
      end
   end

   always_comb begin
      rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (root_start) begin
         rad_ff  <= {best_ff, 16'd0};
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (state_ff == ST_ROOT) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         step_ff <= step_ff + STEP_W'(1);
         if (rem_t >= trial) begin
            rem_ff  <= REM_W'(rem_t - trial);
            root_ff <= {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_t);
            root_ff <= {root_ff[DIST_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.distance <= found_ff ? root_ff : '0;
         rsp_data_ff.found    <= found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `WMCD_ASSERT_IMPL(a_not_found_zero, rsp_valid && !rsp_data.found, rsp_data.distance == '0,
      "Result without a match carries a nonzero distance.")
   `WMCD_ASSERT_NEVER(a_pipe_empty_in_root, state_ff == ST_ROOT && (rd_vld_ff || sq_vld_ff),
      "Square root started before the read pipeline drained.")
   `WMCD_ASSERT_NEXT(a_root_length,
      state_ff == ST_ROOT && step_ff != STEP_W'(ROOT_STEPS - 1), state_ff == ST_ROOT,
      "Square root left before all result bits were formed.")

endmodule
